// File: rtl/core/gls_pkg.sv
// Package for the grid Laplacian stencil core: sizes, configuration codes,
// and the job record passed from the front end through the queue to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gls_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_LAYERS = 1024;
    localparam int DATA_BITS  = 32;

    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int LAYER_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LAYERS_W = $clog2(MAX_LAYERS + 1);
    localparam int CFG_W    = 11;

    localparam int COLS_RESET = (1024 > MAX_COLS) ? MAX_COLS : 1024;
    localparam int ROWS_RESET = (1024 > MAX_ROWS) ? MAX_ROWS : 1024;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef logic [63:0] word_t;

    typedef enum logic [7:0] {
        CFG_COLS   = 8'd0,
        CFG_ROWS   = 8'd1,
        CFG_LAYERS = 8'd2,
        CFG_SCALE  = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [9:0] out_col;
        logic [9:0] out_row;
        logic       eol;
        logic       eog;
    } meta_t;

    typedef struct packed {
        word_t west;
        word_t centre;
        word_t east;
        word_t north;
        word_t south;
        meta_t meta;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/core/gls_bank.sv
// One line-buffer bank: MAX_COLS words, one write port, two registered read ports.
// A read of the address being written returns the new word.
// Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gls_bank (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [gls_pkg::COL_W-1:0] waddr,
    input  wire gls_pkg::word_t           wdata,
    input  wire logic [gls_pkg::COL_W-1:0] raddr0,
    input  wire logic [gls_pkg::COL_W-1:0] raddr1,
    output gls_pkg::word_t                rdata0,
    output gls_pkg::word_t                rdata1
);
    import gls_pkg::*;

    word_t mem [MAX_COLS];
    word_t rdata0_reg;
    word_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0_reg <= (we && waddr == raddr0) ? wdata : mem[raddr0];
        rdata1_reg <= (we && waddr == raddr1) ? wdata : mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// File: rtl/core/gls_front.sv
// Front end: configuration registers, raster counters, two line-buffer banks,
// and classification of each input item into a stencil job for the queue.
// Depends on gls_pkg and gls_bank.
`timescale 1ns / 1ps
`default_nettype none

module gls_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        cfg_valid,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        q_full,
    output logic             push,
    output gls_pkg::job_t    job,
    output logic [31:0]      scale
);
    import gls_pkg::*;

    localparam int CMP_W = COLS_W + 1;

    function automatic logic [CFG_W-1:0] clampcfg(input logic [CFG_W-1:0] v, input int maxv);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (int'(v) > maxv)
        begin
            r = CFG_W'(maxv);
        end
        return r;
    endfunction

    logic [COLS_W-1:0]   cols_reg, cols_next;
    logic [ROWS_W-1:0]   rows_reg, rows_next;
    logic [LAYERS_W-1:0] layers_reg, layers_next;
    logic [31:0]         scale_reg, scale_next;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROWS_W-1:0]   row_reg, row_next;
    logic [LAYER_W-1:0]  layer_reg, layer_next;
    logic [COL_W-1:0]    drain_reg, drain_next;
    word_t               prev_centre_reg;

    logic                in_fire;
    logic                phase_drain;
    logic                phase_drain_nx;
    logic                wr_en;
    logic                emit;
    logic                eol;
    logic                eog;
    logic [COL_W-1:0]    c_cur;
    logic [COL_W-1:0]    c_nx;
    logic [COL_W-1:0]    raddr0;
    logic [COL_W-1:0]    raddr1;
    logic                nb;
    logic                north_ok;
    logic                east_ok;
    logic [ROWS_W-1:0]   row_idx;
    logic [CMP_W-1:0]    d_inc;
    logic [LAYERS_W:0]   l_inc;
    word_t               b0_rd0, b0_rd1, b1_rd0, b1_rd1;
    word_t               north, centre, east, west, south;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && !q_full;
    assign scale    = scale_reg;

    always_comb
    begin
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        layers_next = layers_reg;
        scale_next  = scale_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLS:   cols_next   = COLS_W'(clampcfg(cfg_data[CFG_W-1:0], MAX_COLS));
                CFG_ROWS:   rows_next   = ROWS_W'(clampcfg(cfg_data[CFG_W-1:0], MAX_ROWS));
                CFG_LAYERS: layers_next = LAYERS_W'(clampcfg(cfg_data[CFG_W-1:0], MAX_LAYERS));
                CFG_SCALE:  scale_next  = cfg_data;
                default:    ;
            endcase
        end
    end

    assign phase_drain = row_reg >= rows_reg;
    assign c_cur       = phase_drain ? drain_reg : col_reg;
    assign nb          = phase_drain ? rows_reg[0] : row_reg[0];
    assign north_ok    = phase_drain ? (rows_reg >= ROWS_W'(2)) : (row_reg >= ROWS_W'(2));
    assign east_ok     = (CMP_W'(c_cur) + CMP_W'(1)) < CMP_W'(cols_reg);
    assign row_idx     = (phase_drain ? rows_reg : row_reg) - ROWS_W'(1);
    assign d_inc       = CMP_W'(drain_reg) + CMP_W'(1);
    assign l_inc       = (LAYERS_W + 1)'(layer_reg) + (LAYERS_W + 1)'(1);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        layer_next = layer_reg;
        wr_en      = 1'b0;
        emit       = 1'b0;
        eol        = 1'b0;
        eog        = 1'b0;
        if (in_fire)
        begin
            if (!s_tuser && !phase_drain)
            begin
                wr_en = 1'b1;
                emit  = row_reg != '0;
                if ((CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(cols_reg))
                begin
                    col_next = '0;
                    row_next = row_reg + ROWS_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            else if (s_tuser && phase_drain)
            begin
                emit = 1'b1;
                eol  = d_inc >= CMP_W'(cols_reg);
                if (eol)
                begin
                    eog        = l_inc >= (LAYERS_W + 1)'(layers_reg);
                    drain_next = '0;
                    row_next   = '0;
                    col_next   = '0;
                    layer_next = eog ? '0 : LAYER_W'(l_inc);
                end
                else
                begin
                    drain_next = COL_W'(d_inc);
                end
            end
        end
    end

    assign phase_drain_nx = row_next >= rows_next;
    assign c_nx           = phase_drain_nx ? drain_next : col_next;
    assign raddr0         = c_nx;
    assign raddr1         = c_nx + COL_W'(1);

    gls_bank u_bank0 (
        .clk    (clk),
        .we     (wr_en && !nb),
        .waddr  (col_reg),
        .wdata  (s_tdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b0_rd0),
        .rdata1 (b0_rd1)
    );

    gls_bank u_bank1 (
        .clk    (clk),
        .we     (wr_en && nb),
        .waddr  (col_reg),
        .wdata  (s_tdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b1_rd0),
        .rdata1 (b1_rd1)
    );

    assign north  = !north_ok ? '0 : (nb ? b1_rd0 : b0_rd0);
    assign centre = nb ? b0_rd0 : b1_rd0;
    assign east   = !east_ok ? '0 : (nb ? b0_rd1 : b1_rd1);
    assign west   = (c_cur != '0) ? prev_centre_reg : '0;
    assign south  = phase_drain ? '0 : s_tdata;

    assign push             = emit;
    assign job.west         = west;
    assign job.centre       = centre;
    assign job.east         = east;
    assign job.north        = north;
    assign job.south        = south;
    assign job.meta.out_col = 10'(c_cur);
    assign job.meta.out_row = 10'(row_idx);
    assign job.meta.eol     = eol;
    assign job.meta.eog     = eog;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= COLS_W'(COLS_RESET);
            rows_reg   <= ROWS_W'(ROWS_RESET);
            layers_reg <= LAYERS_W'(1);
            scale_reg  <= 32'd65536;
            col_reg    <= '0;
            row_reg    <= '0;
            layer_reg  <= '0;
            drain_reg  <= '0;
        end
        else
        begin
            cols_reg   <= cols_next;
            rows_reg   <= rows_next;
            layers_reg <= layers_next;
            scale_reg  <= scale_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            layer_reg  <= layer_next;
            drain_reg  <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            prev_centre_reg <= centre;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gls_queue.sv
// Short job queue between the front end and the back end.
// Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gls_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire gls_pkg::job_t push_job,
    input  wire logic          pop,
    output gls_pkg::job_t      head,
    output logic               full,
    output logic               empty
);
    import gls_pkg::*;

    job_t              slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head  = slots[rd_ptr_reg];
    assign full  = count_reg == QCNT_W'(QDEPTH);
    assign empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gls_back.sv
// Back end: three-stage stencil datapath (sum and magnitude, scale multiply,
// round and saturate into the output register).
// Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gls_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gls_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    input  wire logic [31:0]   scale,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        lap_re,
    output logic [31:0]        lap_im,
    output gls_pkg::meta_t     meta,
    output logic               saturated
);
    import gls_pkg::*;

    localparam int SUM_W  = 36;
    localparam int MAG_W  = 34;
    localparam int PROD_W = MAG_W + 16;
    localparam int Q_W    = PROD_W + 1;
    localparam logic [Q_W-1:0] PMAX  = Q_W'((64'd1 << (DATA_BITS - 1)) - 64'd1);
    localparam logic [Q_W-1:0] ROUND = Q_W'(32'h8000);

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } lane_t;

    function automatic logic signed [SUM_W-1:0] sx(input logic [31:0] v);
        return SUM_W'($signed(v[DATA_BITS-1:0]));
    endfunction

    function automatic logic signed [SUM_W-1:0] stencil_sum(
        input logic [31:0] w, input logic [31:0] e, input logic [31:0] n,
        input logic [31:0] s, input logic [31:0] c);
        return sx(w) + sx(e) + sx(n) + sx(s) - (sx(c) <<< 2);
    endfunction

    function automatic lane_t round_sat(input logic [PROD_W-1:0] ph,
                                        input logic [PROD_W-1:0] pl,
                                        input logic neg);
        logic [Q_W-1:0] q;
        lane_t          r;
        q = Q_W'(ph) + ((Q_W'(pl) + ROUND) >> 16);
        r.sat = 1'b0;
        if (!neg)
        begin
            if (q > PMAX)
            begin
                q     = PMAX;
                r.sat = 1'b1;
            end
            r.val = 32'(q);
        end
        else
        begin
            if (q > PMAX + Q_W'(1))
            begin
                q     = PMAX + Q_W'(1);
                r.sat = 1'b1;
            end
            r.val = 32'(~q + Q_W'(1));
        end
        return r;
    endfunction

    logic                     en;
    logic signed [SUM_W-1:0]  sum_re, sum_im;

    logic                     s1_valid_reg;
    logic [MAG_W-1:0]         s1_mag_re_reg, s1_mag_im_reg;
    logic                     s1_neg_re_reg, s1_neg_im_reg;
    meta_t                    s1_meta_reg;

    logic                     s2_valid_reg;
    logic [PROD_W-1:0]        s2_ph_re_reg, s2_pl_re_reg, s2_ph_im_reg, s2_pl_im_reg;
    logic                     s2_neg_re_reg, s2_neg_im_reg;
    meta_t                    s2_meta_reg;

    logic                     out_valid_reg;
    logic [31:0]              out_re_reg, out_im_reg;
    logic                     out_sat_reg;
    meta_t                    out_meta_reg;

    lane_t                    lane_re, lane_im;

    assign en  = !out_valid_reg || m_tready;
    assign pop = en && !empty;

    assign sum_re = stencil_sum(head.west[31:0], head.east[31:0], head.north[31:0],
                                head.south[31:0], head.centre[31:0]);
    assign sum_im = stencil_sum(head.west[63:32], head.east[63:32], head.north[63:32],
                                head.south[63:32], head.centre[63:32]);

    assign lane_re = round_sat(s2_ph_re_reg, s2_pl_re_reg, s2_neg_re_reg);
    assign lane_im = round_sat(s2_ph_im_reg, s2_pl_im_reg, s2_neg_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= !empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_re_reg <= sum_re < 0;
            s1_neg_im_reg <= sum_im < 0;
            s1_mag_re_reg <= MAG_W'((sum_re < 0) ? -sum_re : sum_re);
            s1_mag_im_reg <= MAG_W'((sum_im < 0) ? -sum_im : sum_im);
            s1_meta_reg   <= head.meta;

            s2_ph_re_reg  <= PROD_W'(s1_mag_re_reg) * PROD_W'(scale[31:16]);
            s2_pl_re_reg  <= PROD_W'(s1_mag_re_reg) * PROD_W'(scale[15:0]);
            s2_ph_im_reg  <= PROD_W'(s1_mag_im_reg) * PROD_W'(scale[31:16]);
            s2_pl_im_reg  <= PROD_W'(s1_mag_im_reg) * PROD_W'(scale[15:0]);
            s2_neg_re_reg <= s1_neg_re_reg;
            s2_neg_im_reg <= s1_neg_im_reg;
            s2_meta_reg   <= s1_meta_reg;

            out_re_reg    <= lane_re.val;
            out_im_reg    <= lane_im.val;
            out_sat_reg   <= lane_re.sat || lane_im.sat;
            out_meta_reg  <= s2_meta_reg;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign lap_re    = out_re_reg;
    assign lap_im    = out_im_reg;
    assign meta      = out_meta_reg;
    assign saturated = out_sat_reg;

endmodule

`default_nettype wire

// File: rtl/core/grid_laplacian_stencil_core.sv
// Top level of the grid Laplacian stencil core: front end, job queue, back end.
// Depends on gls_pkg, gls_front, gls_queue and gls_back.
//
// Usage:
//   s_* carries grid samples in raster order (column, row, layer); s_tuser = 1
//   marks a drain item that flushes one point of the last row of a layer.
//   m_* carries one result per point: tlast marks the last point of a layer.
//   cfg_* writes grid width, rows per layer, layers and scale; it is always ready
//   and must be written only while the block is idle; the block does not enforce this.
// Throughput: one item per cycle while s_tready is high, set by the two-bank line
//   buffer whose two registered read ports are prefetched from the raster counters.
// Path: the item that completes its point is registered in the job queue, then in
//   the sum stage, the multiply stage and the output register; the point itself
//   completes when the sample one row below arrives, or on a drain item.
// Reset: counters clear, registers take width 1024, rows 1024, one layer,
//   scale 1.0; line buffer contents are undefined and are never read before
//   being written in a normal run.
// Stall: while a valid result waits on a low m_tready, it holds and the datapath
//   stops; the 4-entry job queue fills and then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module grid_laplacian_stencil_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // sample_re[31:0], sample_im[63:32]
    input  wire logic        s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // lap_re[31:0], lap_im[63:32], out_col[73:64],
                                        // out_row[83:74], zero[87:84]
    output logic [1:0]       m_tuser,   // saturated[0], end_of_grid[1]
    output logic             m_tlast,   // end_of_layer
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import gls_pkg::*;

    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        head;
    logic [31:0] scale;
    logic [31:0] lap_re;
    logic [31:0] lap_im;
    meta_t       meta;
    logic        saturated;

    assign cfg_ready = 1'b1;

    gls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job),
        .scale     (scale)
    );

    gls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    gls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .scale     (scale),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .lap_re    (lap_re),
        .lap_im    (lap_im),
        .meta      (meta),
        .saturated (saturated)
    );

    assign m_tdata = {4'b0000, meta.out_row, meta.out_col, lap_im, lap_re};
    assign m_tuser = {meta.eog, saturated};
    assign m_tlast = meta.eol;

endmodule

`default_nettype wire
